// File: src/text_console_cursor_control_unit_defines.svh
// assertion helpers shared by the console cursor blocks
`ifndef TEXT_CONSOLE_CURSOR_CONTROL_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_CONTROL_UNIT_DEFINES_SVH

// same-cycle implication
`define TCCU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tccu same-cycle check failed");

// next-cycle implication
`define TCCU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tccu next-cycle check failed");

`endif

// File: src/tccu_pkg.sv
package tccu_pkg;

	// character codes with a meaning of their own
	localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
	localparam logic [7:0] CHAR_TAB       = 8'd9;
	localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
	localparam logic [7:0] CHAR_VTAB      = 8'd11;
	localparam logic [7:0] CHAR_FORMFEED  = 8'd12;
	localparam logic [7:0] CHAR_RETURN    = 8'd13;
	localparam logic [7:0] CHAR_BELL      = 8'd7;
	localparam logic [7:0] CHAR_SPACE     = 8'd32;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_FONT_SCALE  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DISP_WIDTH  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DISP_HEIGHT = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND  = 2'd3;
	localparam int unsigned CFG_DATA_W = 24;

	localparam logic [3:0]  RESET_FONT_SCALE  = 4'd1;
	localparam logic [12:0] RESET_DISP_WIDTH  = 13'd1024;
	localparam logic [12:0] RESET_DISP_HEIGHT = 13'd768;
	localparam logic [23:0] RESET_BACKGROUND  = 24'd0;

	// scroll strip is always this wide
	localparam logic [12:0] STRIP_WIDTH = 13'd1024;

	// request queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		CLS_BACKSPACE,
		CLS_BLANK,
		CLS_NEWLINE,
		CLS_TAB,
		CLS_GLYPH
	} cls_t;

	typedef enum logic [1:0] {
		ACT_GLYPH  = 2'd0,
		ACT_CLEAR  = 2'd1,
		ACT_SCROLL = 2'd2
	} act_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_EXEC,
		BK_WRAP,
		BK_SCROLL,
		BK_GLYPH,
		BK_DIV,
		BK_TAB_MUL,
		BK_TAB_ADD,
		BK_DONE
	} bk_state_t;

	typedef struct packed {
		cls_t        cls;
		logic [7:0]  code;
		logic [23:0] color;
		logic        at;
		logic [11:0] gx;
		logic [11:0] gy;
	} item_t;

	typedef struct packed {
		logic [3:0]  font_scale;
		logic [12:0] disp_width;
		logic [12:0] disp_height;
		logic [23:0] background_color;
	} cfg_t;

	typedef struct packed {
		act_t        action;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [12:0] rect_width;
		logic [12:0] rect_height;
		logic [7:0]  glyph_code;
		logic [23:0] fill_color;
		logic        last;
	} res_t;

endpackage

// File: src/tccu_front.sv
module tccu_front (
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [7:0]           char_code,
	input  logic [23:0]          text_color,
	input  logic                 at_position,
	input  logic [11:0]          given_x,
	input  logic [11:0]          given_y,
	input  logic                 q_full,
	output logic                 q_push,
	output tccu_pkg::item_t      q_item
);

	tccu_pkg::cls_t cls;

	always_comb begin
		case (char_code)
			tccu_pkg::CHAR_BACKSPACE: cls = tccu_pkg::CLS_BACKSPACE;
			tccu_pkg::CHAR_NEWLINE:   cls = tccu_pkg::CLS_NEWLINE;
			tccu_pkg::CHAR_TAB:       cls = tccu_pkg::CLS_TAB;
			tccu_pkg::CHAR_SPACE,
			tccu_pkg::CHAR_VTAB,
			tccu_pkg::CHAR_RETURN,
			tccu_pkg::CHAR_BELL,
			tccu_pkg::CHAR_FORMFEED:  cls = tccu_pkg::CLS_BLANK;
			default:                  cls = tccu_pkg::CLS_GLYPH;
		endcase
	end

	assign req_stall = q_full;
	assign q_push    = req_valid && !q_full;

	always_comb begin
		q_item.cls   = cls;
		q_item.code  = char_code;
		q_item.color = text_color;
		q_item.at    = at_position;
		q_item.gx    = given_x;
		q_item.gy    = given_y;
	end

endmodule

// File: src/tccu_queue.sv
`include "text_console_cursor_control_unit_defines.svh"

module tccu_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tccu_pkg::item_t  push_item,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output tccu_pkg::item_t  pop_item
);

	tccu_pkg::item_t                       entry_q [tccu_pkg::QUEUE_DEPTH];
	logic [tccu_pkg::QUEUE_PTR_W-1:0]      wr_ptr_q;
	logic [tccu_pkg::QUEUE_PTR_W-1:0]      rd_ptr_q;
	logic [tccu_pkg::QUEUE_CNT_W-1:0]      count_q;

	assign full      = (count_q == tccu_pkg::QUEUE_CNT_W'(tccu_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + tccu_pkg::QUEUE_PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + tccu_pkg::QUEUE_PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + tccu_pkg::QUEUE_CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - tccu_pkg::QUEUE_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_item;
	end

	`TCCU_ASSERT_NEXT(a_q_fill, clk, arst_n, push && !pop, count_q == $past(count_q) + tccu_pkg::QUEUE_CNT_W'(1))
	`TCCU_ASSERT_SAME(a_q_ptrs, clk, arst_n, count_q == '0, wr_ptr_q == rd_ptr_q)

endmodule

// File: src/tccu_back.sv
`include "text_console_cursor_control_unit_defines.svh"

module tccu_back #(
	parameter int unsigned TAB_STOP_CELLS = 5,
	parameter int unsigned CURSOR_BITS    = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tccu_pkg::cfg_t   cfg,
	input  logic             q_valid,
	input  tccu_pkg::item_t  q_item,
	output logic             q_pop,
	output logic             cmd_valid,
	input  logic             cmd_stall,
	output tccu_pkg::res_t   cmd
);

	localparam int unsigned CB   = CURSOR_BITS;
	localparam int unsigned CNTW = $clog2(CB);
	localparam int unsigned TW   = $clog2(TAB_STOP_CELLS + 1);
	localparam int unsigned PW   = TW + 7;

	function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] a, input logic [CB-1:0] b);
		logic [CB:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CB] ? '1 : s[CB-1:0];
	endfunction

	function automatic logic [CB-1:0] clamp_sub(input logic [CB-1:0] a, input logic [CB-1:0] b);
		return (a > b) ? a - b : '0;
	endfunction

	tccu_pkg::bk_state_t state_q, state_d;
	tccu_pkg::item_t     item_q, item_d;
	tccu_pkg::res_t      res_q, res_d;
	logic                out_valid_q;
	logic                res_load;
	logic                out_free;

	logic [CB-1:0]   cx_q, cx_d, cy_q, cy_d;
	logic [CB-1:0]   wx_q, wx_d, wy_q, wy_d;
	logic [6:0]      rem_q, rem_d;
	logic [TW-1:0]   r_q, r_d;
	logic [CNTW-1:0] cnt_q, cnt_d;
	logic [PW-1:0]   prod_q, prod_d;

	logic [6:0]      cw7;
	logic [7:0]      ch8;
	logic [CB-1:0]   cw_c, ch_c, sw_c, sh_c;
	logic [12:0]     sw_back, sh_back;
	logic [CB-1:0]   bs_x, bs_y;
	logic            is_nl;

	// tab divider: one quotient bit a cycle, quotient kept modulo the tab stop
	logic [7:0]      trial;
	logic            qbit;
	logic [6:0]      rem_next;
	logic [TW:0]     r2;
	logic [TW-1:0]   r_next;
	logic [TW-1:0]   steps;

	assign cw7  = {cfg.font_scale, 3'b000};
	assign ch8  = {cfg.font_scale, 4'b0000};
	assign cw_c = CB'(cw7);
	assign ch_c = CB'(ch8);
	assign sw_c = CB'(cfg.disp_width);
	assign sh_c = CB'(cfg.disp_height);
	assign sw_back = (cfg.disp_width > 13'(cw7)) ? cfg.disp_width - 13'(cw7) : '0;
	assign sh_back = (cfg.disp_height > 13'(ch8)) ? cfg.disp_height - 13'(ch8) : '0;
	assign is_nl   = (item_q.cls == tccu_pkg::CLS_NEWLINE);

	// backspace at column zero steps to the last cell of the line above
	assign bs_x = (wx_q != '0) ? clamp_sub(wx_q, cw_c) :
	              (wy_q != '0) ? CB'(sw_back) : wx_q;
	assign bs_y = (wx_q == '0 && wy_q != '0) ? clamp_sub(wy_q, ch_c) : wy_q;

	assign trial    = {rem_q, wx_q[cnt_q]};
	assign qbit     = (trial >= {1'b0, cw7});
	assign rem_next = qbit ? 7'(trial - {1'b0, cw7}) : trial[6:0];
	assign r2       = {r_q, qbit};
	assign r_next   = (r2 >= (TW+1)'(TAB_STOP_CELLS)) ? TW'(r2 - (TW+1)'(TAB_STOP_CELLS))
	                                                  : TW'(r2);
	assign steps    = TW'(TAB_STOP_CELLS) - r_q;

	assign out_free  = !out_valid_q || !cmd_stall;
	assign cmd_valid = out_valid_q;
	assign cmd       = res_q;

	always_comb begin
		state_d  = state_q;
		item_d   = item_q;
		res_d    = res_q;
		res_load = 1'b0;
		q_pop    = 1'b0;
		cx_d     = cx_q;
		cy_d     = cy_q;
		wx_d     = wx_q;
		wy_d     = wy_q;
		rem_d    = rem_q;
		r_d      = r_q;
		cnt_d    = cnt_q;
		prod_d   = prod_q;
		case (state_q)
			tccu_pkg::BK_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					item_d  = q_item;
					wx_d    = q_item.at ? CB'(q_item.gx) : cx_q;
					wy_d    = q_item.at ? CB'(q_item.gy) : cy_q;
					state_d = tccu_pkg::BK_EXEC;
				end
			end
			tccu_pkg::BK_EXEC: begin
				case (item_q.cls)
					tccu_pkg::CLS_BACKSPACE: begin
						if (out_free) begin
							res_load          = 1'b1;
							res_d.action      = tccu_pkg::ACT_CLEAR;
							res_d.pos_x       = 16'(bs_x);
							res_d.pos_y       = 16'(bs_y);
							res_d.rect_width  = 13'(cw7);
							res_d.rect_height = 13'(ch8);
							res_d.glyph_code  = '0;
							res_d.fill_color  = cfg.background_color;
							res_d.last        = 1'b1;
							wx_d              = bs_x;
							wy_d              = bs_y;
							state_d           = tccu_pkg::BK_DONE;
						end
					end
					tccu_pkg::CLS_BLANK: begin
						wx_d    = sat_add(wx_q, cw_c);
						state_d = tccu_pkg::BK_DONE;
					end
					tccu_pkg::CLS_NEWLINE: begin
						wx_d    = '0;
						wy_d    = sat_add(wy_q, ch_c);
						state_d = tccu_pkg::BK_WRAP;
					end
					tccu_pkg::CLS_TAB: begin
						// zero scale: tab does not move
						if (cw7 == '0) begin
							state_d = tccu_pkg::BK_DONE;
						end else begin
							cnt_d   = CNTW'(CB - 1);
							rem_d   = '0;
							r_d     = '0;
							state_d = tccu_pkg::BK_DIV;
						end
					end
					default: state_d = tccu_pkg::BK_WRAP;
				endcase
			end
			tccu_pkg::BK_WRAP: begin
				if (wx_q >= sw_c) begin
					wx_d = '0;
					wy_d = sat_add(wy_q, ch_c);
				end
				state_d = tccu_pkg::BK_SCROLL;
			end
			tccu_pkg::BK_SCROLL: begin
				if (wy_q >= sh_c) begin
					if (out_free) begin
						res_load          = 1'b1;
						res_d.action      = tccu_pkg::ACT_SCROLL;
						res_d.pos_x       = '0;
						res_d.pos_y       = 16'(sh_back);
						res_d.rect_width  = tccu_pkg::STRIP_WIDTH;
						res_d.rect_height = 13'(ch8);
						res_d.glyph_code  = '0;
						res_d.fill_color  = cfg.background_color;
						res_d.last        = is_nl;
						wx_d              = '0;
						wy_d              = clamp_sub(wy_q, ch_c);
						state_d           = is_nl ? tccu_pkg::BK_DONE : tccu_pkg::BK_GLYPH;
					end
				end else begin
					state_d = is_nl ? tccu_pkg::BK_DONE : tccu_pkg::BK_GLYPH;
				end
			end
			tccu_pkg::BK_GLYPH: begin
				if (out_free) begin
					res_load          = 1'b1;
					res_d.action      = tccu_pkg::ACT_GLYPH;
					res_d.pos_x       = 16'(wx_q);
					res_d.pos_y       = 16'(wy_q);
					res_d.rect_width  = '0;
					res_d.rect_height = '0;
					res_d.glyph_code  = item_q.code;
					res_d.fill_color  = item_q.color;
					res_d.last        = 1'b1;
					wx_d              = sat_add(wx_q, cw_c);
					state_d           = tccu_pkg::BK_DONE;
				end
			end
			tccu_pkg::BK_DIV: begin
				rem_d = rem_next;
				r_d   = r_next;
				cnt_d = cnt_q - CNTW'(1);
				if (cnt_q == '0)
					state_d = tccu_pkg::BK_TAB_MUL;
			end
			tccu_pkg::BK_TAB_MUL: begin
				prod_d  = PW'(steps) * PW'(cw7);
				state_d = tccu_pkg::BK_TAB_ADD;
			end
			tccu_pkg::BK_TAB_ADD: begin
				wx_d    = sat_add(wx_q, CB'(prod_q));
				state_d = tccu_pkg::BK_DONE;
			end
			tccu_pkg::BK_DONE: begin
				// a positioned request leaves the cursor where it was
				if (!item_q.at) begin
					cx_d = wx_q;
					cy_d = wy_q;
				end
				state_d = tccu_pkg::BK_IDLE;
			end
			default: state_d = tccu_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tccu_pkg::BK_IDLE;
			cx_q        <= '0;
			cy_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cx_q    <= cx_d;
			cy_q    <= cy_d;
			if (res_load)
				out_valid_q <= 1'b1;
			else if (!cmd_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		item_q <= item_d;
		res_q  <= res_d;
		wx_q   <= wx_d;
		wy_q   <= wy_d;
		rem_q  <= rem_d;
		r_q    <= r_d;
		cnt_q  <= cnt_d;
		prod_q <= prod_d;
	end

	`TCCU_ASSERT_NEXT(a_at_restore, clk, arst_n, state_q == tccu_pkg::BK_DONE && item_q.at, $stable(cx_q) && $stable(cy_q))
	`TCCU_ASSERT_SAME(a_div_bounds, clk, arst_n, state_q == tccu_pkg::BK_DIV, rem_q < cw7 && r_q < TW'(TAB_STOP_CELLS))
	`TCCU_ASSERT_SAME(a_scroll_last, clk, arst_n, res_load && res_d.action == tccu_pkg::ACT_SCROLL, res_d.last == is_nl)
	`TCCU_ASSERT_NEXT(a_out_load, clk, arst_n, res_load, out_valid_q && res_q == $past(res_d))

endmodule

// File: src/text_console_cursor_control_unit.sv
// Text cursor controller for a console of 8x16 character cells scaled by font_scale. Each
// request carries one character byte and a colour and yields zero, one or two draw commands on
// the cmd channel (a newline may give a one-line scroll, a glyph an optional scroll then a glyph
// draw, a backspace a cell clear; last marks the final one). Requests go through a two-entry
// queue, so up to two can be taken while the back end is still busy or a command waits on
// cmd_stall. The back end handles one request at a time, each through the IDLE, EXEC and DONE
// states; a newline or a glyph also passes WRAP and SCROLL, a glyph GLYPH, and a tab DIV,
// TAB_MUL and TAB_ADD, where a bit-serial divider finds the current cell column modulo the
// tab stop. Configuration registers may only be written while no request is in flight.
module text_console_cursor_control_unit #(
	parameter int unsigned TAB_STOP_CELLS = 5,
	parameter int unsigned CURSOR_BITS    = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [tccu_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [tccu_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
	input  logic                                  req_valid,
	output logic                                  req_stall,
	input  logic [7:0]                            char_code,
	input  logic [23:0]                           text_color,
	input  logic                                  at_position,
	input  logic [11:0]                           given_x,
	input  logic [11:0]                           given_y,
	output logic                                  cmd_valid,
	input  logic                                  cmd_stall,
	output logic [1:0]                            action,
	output logic [15:0]                           pos_x,
	output logic [15:0]                           pos_y,
	output logic [12:0]                           rect_width,
	output logic [12:0]                           rect_height,
	output logic [7:0]                            glyph_code,
	output logic [23:0]                           fill_color,
	output logic                                  last
);

	tccu_pkg::cfg_t  cfg_q;
	tccu_pkg::item_t push_item;
	tccu_pkg::item_t pop_item;
	tccu_pkg::res_t  cmd;
	logic            q_full;
	logic            q_push;
	logic            q_pop;
	logic            q_not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.font_scale       <= tccu_pkg::RESET_FONT_SCALE;
			cfg_q.disp_width       <= tccu_pkg::RESET_DISP_WIDTH;
			cfg_q.disp_height      <= tccu_pkg::RESET_DISP_HEIGHT;
			cfg_q.background_color <= tccu_pkg::RESET_BACKGROUND;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				tccu_pkg::REG_FONT_SCALE:  cfg_q.font_scale       <= cfg_wr_data[3:0];
				tccu_pkg::REG_DISP_WIDTH:  cfg_q.disp_width       <= cfg_wr_data[12:0];
				tccu_pkg::REG_DISP_HEIGHT: cfg_q.disp_height      <= cfg_wr_data[12:0];
				tccu_pkg::REG_BACKGROUND:  cfg_q.background_color <= cfg_wr_data[23:0];
				default: ;
			endcase
		end
	end

	tccu_front u_front (
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.char_code   (char_code),
		.text_color  (text_color),
		.at_position (at_position),
		.given_x     (given_x),
		.given_y     (given_y),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_item      (push_item)
	);

	tccu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_item  (pop_item)
	);

	tccu_back #(
		.TAB_STOP_CELLS (TAB_STOP_CELLS),
		.CURSOR_BITS    (CURSOR_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_not_empty),
		.q_item    (pop_item),
		.q_pop     (q_pop),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd)
	);

	assign action      = cmd.action;
	assign pos_x       = cmd.pos_x;
	assign pos_y       = cmd.pos_y;
	assign rect_width  = cmd.rect_width;
	assign rect_height = cmd.rect_height;
	assign glyph_code  = cmd.glyph_code;
	assign fill_color  = cmd.fill_color;
	assign last        = cmd.last;

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TAB_STOP      = 5;
	localparam int unsigned CURSOR_MAX    = 65535;
	localparam int unsigned SETTLE_CYCLES = 100;
	localparam int unsigned LONG_HOLD     = 400;
	localparam int unsigned CYCLE_LIMIT   = 400000;

	typedef struct {
		logic [7:0]  code;
		logic [23:0] color;
		logic        at;
		logic [11:0] gx;
		logic [11:0] gy;
	} char_req_t;

	logic                             clk         = 1'b0;
	logic                             arst_n      = 1'b0;
	logic                             cfg_wr_en   = 1'b0;
	logic [tccu_pkg::CFG_INDEX_W-1:0] cfg_index   = '0;
	logic [tccu_pkg::CFG_DATA_W-1:0]  cfg_wr_data = '0;
	logic                             req_valid   = 1'b0;
	logic                             req_stall;
	logic [7:0]                       char_code   = '0;
	logic [23:0]                      text_color  = '0;
	logic                             at_position = 1'b0;
	logic [11:0]                      given_x     = '0;
	logic [11:0]                      given_y     = '0;
	logic                             cmd_valid;
	logic                             cmd_stall   = 1'b0;
	logic [1:0]                       action;
	logic [15:0]                      pos_x;
	logic [15:0]                      pos_y;
	logic [12:0]                      rect_width;
	logic [12:0]                      rect_height;
	logic [7:0]                       glyph_code;
	logic [23:0]                      fill_color;
	logic                             last;

	text_console_cursor_control_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wr_data(cfg_wr_data),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.char_code  (char_code),
		.text_color (text_color),
		.at_position(at_position),
		.given_x    (given_x),
		.given_y    (given_y),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.action     (action),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.rect_width (rect_width),
		.rect_height(rect_height),
		.glyph_code (glyph_code),
		.fill_color (fill_color),
		.last       (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the block's registers and cursor
	logic [3:0]  cfg_scale  = tccu_pkg::RESET_FONT_SCALE;
	logic [12:0] cfg_width  = tccu_pkg::RESET_DISP_WIDTH;
	logic [12:0] cfg_height = tccu_pkg::RESET_DISP_HEIGHT;
	logic [23:0] cfg_bg     = tccu_pkg::RESET_BACKGROUND;
	int unsigned col_px     = 0;
	int unsigned row_px     = 0;

	char_req_t       char_requests[$];
	char_req_t       cur_req;
	tccu_pkg::res_t  cmd_expected[$];
	tccu_pkg::res_t  step_cmds[$];
	int              send_idle_pct = 0;
	int              recv_stall_pct = 0;
	bit              long_hold_req = 1'b0;
	int unsigned     hold_left = 0;
	int unsigned     cycle_count = 0;
	int              mismatches = 0;

	function automatic int unsigned sat_add(int unsigned a, int unsigned b);
		int unsigned s;
		s = a + b;
		return (s > CURSOR_MAX) ? CURSOR_MAX : s;
	endfunction

	function automatic int unsigned clamp_sub(int unsigned a, int unsigned b);
		return (a > b) ? a - b : 0;
	endfunction

	function automatic tccu_pkg::res_t make_cmd(tccu_pkg::act_t act, int unsigned x,
		int unsigned y, int unsigned w, int unsigned h, logic [7:0] g, logic [23:0] fill);
		tccu_pkg::res_t r;
		r.action      = act;
		r.pos_x       = x[15:0];
		r.pos_y       = y[15:0];
		r.rect_width  = w[12:0];
		r.rect_height = h[12:0];
		r.glyph_code  = g;
		r.fill_color  = fill;
		r.last        = 1'b0;
		return r;
	endfunction

	// wrap at the right edge, then scroll once if past the bottom
	function void line_check(int unsigned ch);
		if (col_px >= cfg_width) begin
			col_px = 0;
			row_px = sat_add(row_px, ch);
		end
		if (row_px >= cfg_height) begin
			col_px = 0;
			step_cmds.push_back(make_cmd(tccu_pkg::ACT_SCROLL, 0, clamp_sub(cfg_height, ch),
				tccu_pkg::STRIP_WIDTH, ch, 8'd0, cfg_bg));
			row_px = clamp_sub(row_px, ch);
		end
	endfunction

	function void predict_commands(char_req_t r);
		int unsigned cw, ch, save_col, save_row, cells, steps;
		tccu_pkg::res_t c;
		cw = 8 * cfg_scale;
		ch = 16 * cfg_scale;
		save_col = col_px;
		save_row = row_px;
		step_cmds.delete();
		if (r.at) begin
			col_px = r.gx;
			row_px = r.gy;
		end
		case (r.code)
			tccu_pkg::CHAR_BACKSPACE: begin
				if (col_px > 0) begin
					col_px = clamp_sub(col_px, cw);
				end else if (row_px > 0) begin
					row_px = clamp_sub(row_px, ch);
					col_px = clamp_sub(cfg_width, cw);
				end
				step_cmds.push_back(make_cmd(tccu_pkg::ACT_CLEAR, col_px, row_px, cw, ch,
					8'd0, cfg_bg));
			end
			tccu_pkg::CHAR_SPACE, tccu_pkg::CHAR_VTAB, tccu_pkg::CHAR_RETURN,
			tccu_pkg::CHAR_BELL, tccu_pkg::CHAR_FORMFEED: begin
				col_px = sat_add(col_px, cw);
			end
			tccu_pkg::CHAR_NEWLINE: begin
				col_px = 0;
				row_px = sat_add(row_px, ch);
				line_check(ch);
			end
			tccu_pkg::CHAR_TAB: begin
				if (cw != 0) begin
					cells = col_px / cw;
					steps = TAB_STOP - cells % TAB_STOP;
					col_px = sat_add(col_px, steps * cw);
				end
			end
			default: begin
				line_check(ch);
				step_cmds.push_back(make_cmd(tccu_pkg::ACT_GLYPH, col_px, row_px, 0, 0,
					r.code, r.color));
				col_px = sat_add(col_px, cw);
			end
		endcase
		if (r.at) begin
			col_px = save_col;
			row_px = save_row;
		end
		foreach (step_cmds[i]) begin
			c = step_cmds[i];
			c.last = (i == step_cmds.size() - 1);
			cmd_expected.push_back(c);
		end
	endfunction

	function automatic char_req_t mk_req(logic [7:0] code, logic [23:0] color, logic at,
		logic [11:0] gx, logic [11:0] gy);
		char_req_t r;
		r.code  = code;
		r.color = color;
		r.at    = at;
		r.gx    = gx;
		r.gy    = gy;
		return r;
	endfunction

	function automatic char_req_t gen_req(bit tab_heavy);
		char_req_t r;
		int unsigned pick;
		logic [7:0] blanks[5];
		blanks = '{tccu_pkg::CHAR_SPACE, tccu_pkg::CHAR_VTAB, tccu_pkg::CHAR_RETURN,
			tccu_pkg::CHAR_BELL, tccu_pkg::CHAR_FORMFEED};
		pick = $urandom_range(99);
		r = mk_req(8'($urandom_range(255)), 24'($urandom), ($urandom_range(9) == 0),
			12'($urandom_range(4095)), 12'($urandom_range(4095)));
		if (tab_heavy) begin
			// long runs of advances without a wrap check push the cursor to saturation
			r.at = 1'b0;
			if (pick < 70)
				r.code = tccu_pkg::CHAR_TAB;
			else if (pick < 98)
				r.code = blanks[$urandom_range(4)];
		end else begin
			if (pick >= 50 && pick < 62)
				r.code = tccu_pkg::CHAR_NEWLINE;
			else if (pick >= 62 && pick < 74)
				r.code = tccu_pkg::CHAR_BACKSPACE;
			else if (pick >= 74 && pick < 84)
				r.code = tccu_pkg::CHAR_TAB;
			else if (pick >= 84)
				r.code = blanks[$urandom_range(4)];
		end
		return r;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid   <= 1'b0;
			char_code   <= '0;
			text_color  <= '0;
			at_position <= 1'b0;
			given_x     <= '0;
			given_y     <= '0;
		end else begin
			if (req_valid && !req_stall)
				predict_commands(cur_req);
			if (!req_valid || !req_stall) begin
				if (char_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_req = char_requests.pop_front();
					char_code   <= cur_req.code;
					text_color  <= cur_req.color;
					at_position <= cur_req.at;
					given_x     <= cur_req.gx;
					given_y     <= cur_req.gy;
					req_valid   <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// command receiver stall, with an occasional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_stall <= 1'b0;
			hold_left = 0;
		end else if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left = LONG_HOLD;
			cmd_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left--;
			cmd_stall <= 1'b1;
		end else begin
			cmd_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
		end
	endtask

	// command monitor
	always @(posedge clk) begin
		tccu_pkg::res_t want;
		if (arst_n && cmd_valid && !cmd_stall) begin
			if (cmd_expected.size() == 0) begin
				mismatches++;
				$error("command with nothing expected: action %0d pos %0d,%0d",
					action, pos_x, pos_y);
			end else begin
				want = cmd_expected.pop_front();
				check_field("action", want.action, action);
				check_field("pos_x", want.pos_x, pos_x);
				check_field("pos_y", want.pos_y, pos_y);
				check_field("rect_width", want.rect_width, rect_width);
				check_field("rect_height", want.rect_height, rect_height);
				check_field("glyph_code", want.glyph_code, glyph_code);
				check_field("fill_color", want.fill_color, fill_color);
				check_field("last", want.last, last);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("text_console_cursor_control_unit regression: fail");
		$finish;
	end

	task automatic write_reg(logic [tccu_pkg::CFG_INDEX_W-1:0] idx,
		logic [tccu_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_index   <= idx;
		cfg_wr_data <= data;
		case (idx)
			tccu_pkg::REG_FONT_SCALE:  cfg_scale  = data[3:0];
			tccu_pkg::REG_DISP_WIDTH:  cfg_width  = data[12:0];
			tccu_pkg::REG_DISP_HEIGHT: cfg_height = data[12:0];
			tccu_pkg::REG_BACKGROUND:  cfg_bg     = data[23:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic write_config(int unsigned scale, int unsigned width, int unsigned height,
		logic [23:0] bg);
		write_reg(tccu_pkg::REG_FONT_SCALE, tccu_pkg::CFG_DATA_W'(scale));
		write_reg(tccu_pkg::REG_DISP_WIDTH, tccu_pkg::CFG_DATA_W'(width));
		write_reg(tccu_pkg::REG_DISP_HEIGHT, tccu_pkg::CFG_DATA_W'(height));
		write_reg(tccu_pkg::REG_BACKGROUND, bg);
	endtask

	// blank and tab requests leave nothing to wait for, so settle afterwards
	task automatic wait_drained();
		do @(posedge clk);
		while (char_requests.size() != 0 || req_valid || cmd_expected.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(int send_pct, int recv_pct, int count, bit tab_heavy);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		repeat (count) char_requests.push_back(gen_req(tab_heavy));
		wait_drained();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_config(1, 1024, 768, 24'hFFFFFF);
		char_requests.push_back(mk_req(tccu_pkg::CHAR_BACKSPACE, 24'h000000, 1'b0, 12'd0, 12'd0));
		char_requests.push_back(mk_req(8'h41, 24'h000000, 1'b0, 12'd0, 12'd0));
		char_requests.push_back(mk_req(8'hFF, 24'hFFFFFF, 1'b0, 12'd0, 12'd0));
		char_requests.push_back(mk_req(8'h00, 24'h123456, 1'b0, 12'd0, 12'd0));
		char_requests.push_back(mk_req(tccu_pkg::CHAR_SPACE, 24'h0, 1'b0, 12'd0, 12'd0));
		char_requests.push_back(mk_req(tccu_pkg::CHAR_VTAB, 24'h0, 1'b0, 12'd0, 12'd0));
		char_requests.push_back(mk_req(tccu_pkg::CHAR_RETURN, 24'h0, 1'b0, 12'd0, 12'd0));
		char_requests.push_back(mk_req(tccu_pkg::CHAR_BELL, 24'h0, 1'b0, 12'd0, 12'd0));
		char_requests.push_back(mk_req(tccu_pkg::CHAR_FORMFEED, 24'h0, 1'b0, 12'd0, 12'd0));
		char_requests.push_back(mk_req(tccu_pkg::CHAR_TAB, 24'h0, 1'b0, 12'd0, 12'd0));
		char_requests.push_back(mk_req(tccu_pkg::CHAR_BACKSPACE, 24'h0, 1'b0, 12'd0, 12'd0));
		char_requests.push_back(mk_req(tccu_pkg::CHAR_NEWLINE, 24'h0, 1'b0, 12'd0, 12'd0));
		// backspace from column zero onto the previous line, row clamped
		char_requests.push_back(mk_req(tccu_pkg::CHAR_BACKSPACE, 24'h0, 1'b1, 12'd0, 12'd5));
		// column below one cell clamps to zero
		char_requests.push_back(mk_req(tccu_pkg::CHAR_BACKSPACE, 24'h0, 1'b1, 12'd3, 12'd0));
		char_requests.push_back(mk_req(8'h5A, 24'hABCDEF, 1'b1, 12'd4095, 12'd4095));
		char_requests.push_back(mk_req(tccu_pkg::CHAR_SPACE, 24'h0, 1'b1, 12'd4095, 12'd0));
		char_requests.push_back(mk_req(tccu_pkg::CHAR_TAB, 24'h0, 1'b1, 12'd4095, 12'd4095));
		char_requests.push_back(mk_req(tccu_pkg::CHAR_NEWLINE, 24'h0, 1'b1, 12'd0, 12'd767));
		char_requests.push_back(mk_req(8'h61, 24'h00FF00, 1'b1, 12'd1023, 12'd752));
		char_requests.push_back(mk_req(8'h62, 24'hFF0000, 1'b1, 12'd1024, 12'd752));
		char_requests.push_back(mk_req(tccu_pkg::CHAR_BACKSPACE, 24'h0, 1'b1, 12'd0, 12'd0));
		char_requests.push_back(mk_req(8'h7F, 24'hFFFFFF, 1'b1, 12'd0, 12'd0));
		run_phase(0, 0, 0, 1'b0);

		write_config(1, 1024, 768, 24'h000000);
		run_phase(0, 0, 150, 1'b0);

		write_config(1, 64, 64, 24'h5A5A5A);
		run_phase(51, 0, 200, 1'b0);

		write_config(2, 4096, 4096, 24'hA5A5A5);
		run_phase(0, 51, 200, 1'b0);

		// smallest screen, largest documented cell
		write_config(8, 8, 16, 24'hFFFFFF);
		run_phase(29, 29, 200, 1'b0);

		write_config(8, 4096, 4096, 24'h0F0F0F);
		run_phase(0, 0, 250, 1'b1);

		// receiver holds off while requests keep coming
		write_config(1, 128, 96, 24'hC0FFEE);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (60) char_requests.push_back(gen_req(1'b0));
		long_hold_req = 1'b1;
		wait_drained();

		write_config(0, 1024, 768, 24'h333333);
		run_phase(29, 29, 50, 1'b0);
		repeat (2) begin
			write_config($urandom_range(8, 1), $urandom_range(4096, 8),
				$urandom_range(4096, 16), 24'($urandom));
			run_phase(29, 29, 50, 1'b0);
		end
		write_config($urandom_range(15, 0), $urandom_range(8191, 0),
			$urandom_range(8191, 0), 24'($urandom));
		run_phase(29, 29, 50, 1'b0);

		if (mismatches == 0)
			$display("text_console_cursor_control_unit regression: pass");
		else
			$display("text_console_cursor_control_unit regression: fail");
		$finish;
	end

endmodule
